// File: rtl/crcs_pkg.sv
package crcs_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CntWidth  = 3;
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CntWidth-1:0] SeedBytes = 3'd4;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [CrcWidth-1:0] checksum;
    logic                too_short;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  // table entry for one top byte, folded through the polynomial
  function automatic logic [CrcWidth-1:0] fold_top(input logic [ByteWidth-1:0] top);
    logic [CrcWidth-1:0] r;
    r = {top, {(CrcWidth-ByteWidth){1'b0}}};
    for (int k = 0; k < ByteWidth; k++) begin
      if (r[CrcWidth-1]) begin
        r = (r << 1) ^ CrcPoly;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/crcs_core.sv
module crcs_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  crcs_pkg::in_beat_t beat_i,
  output crcs_pkg::res_t    res_o
);

  logic [crcs_pkg::CrcWidth-1:0] crc_q, crc_d, shifted, stepped;
  logic [crcs_pkg::CntWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic                          seeding;

  assign seeding = (cnt_q < crcs_pkg::SeedBytes);
  assign cnt_inc = cnt_q + crcs_pkg::CntWidth'(1);
  assign shifted = {crc_q[crcs_pkg::CrcWidth-crcs_pkg::ByteWidth-1:0], beat_i.data_byte};

  always_comb begin
    if (seeding) begin
      stepped = (cnt_inc == crcs_pkg::SeedBytes) ? ~shifted : shifted;
    end else begin
      stepped = crcs_pkg::fold_top(crc_q[crcs_pkg::CrcWidth-1 -: crcs_pkg::ByteWidth])
                ^ shifted;
    end
  end

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    res_o = '0;
    if (accept_i) begin
      crc_d = stepped;
      if (seeding) begin
        cnt_d = cnt_inc;
      end
      if (beat_i.last_byte) begin
        res_o.valid = 1'b1;
        if (seeding && (cnt_inc != crcs_pkg::SeedBytes)) begin
          res_o.beat.checksum  = '0;
          res_o.beat.too_short = 1'b1;
        end else begin
          res_o.beat.checksum  = ~stepped;
          res_o.beat.too_short = 1'b0;
        end
        crc_d = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= crcs_pkg::SeedBytes)
    else $error("byte count past seed length");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && beat_i.last_byte |=> cnt_q == '0 && crc_q == '0)
    else $error("state not cleared after last beat");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> accept_i && beat_i.last_byte)
    else $error("result without last beat");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.beat.too_short |-> res_o.beat.checksum == '0)
    else $error("short message with nonzero checksum");

endmodule

// File: rtl/crcs_out_reg.sv
module crcs_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crcs_pkg::res_t      res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crcs_pkg::out_beat_t out_beat_o
);

  logic                valid_q, valid_d;
  crcs_pkg::out_beat_t beat_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (res_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      beat_q <= res_i.beat;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |-> free_o)
    else $error("result written over pending beat");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_ready_i |-> !free_o)
    else $error("input open while output stalled");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_i.valid |=> valid_q && beat_q == $past(res_i.beat))
    else $error("result not loaded");

endmodule

// File: rtl/crc32_direct_seeded_checksum.sv
// Seeded CRC-32 checksum over a byte stream, non-reflected, polynomial 0x04C11DB7.
// Input channel in_valid_i / in_ready_o / in_beat_i: one message byte per beat,
// last_byte set on the final byte of a message. The first four bytes form the
// inverted big-endian seed; each later byte is folded in with one table step.
// Output channel out_valid_o / out_ready_i / out_beat_o: one beat per message,
// produced only for the byte marked last. checksum is the inverted register, or
// 0 with too_short set when the message had fewer than four bytes.
// Throughput: one input byte per cycle while in_ready_o is high, set by the single
// table lookup and xor between the input handshake and the crc register.
// Latency: the result beat is valid in the cycle after the last byte is taken.
// Reset clears the crc register, the byte count and the output valid, so the
// first byte after reset starts a new message.
// When the receiver stalls with a result pending, in_ready_o drops until the
// result is taken; bytes that are not last keep flowing only while the output
// register is free or being drained.
module crc32_direct_seeded_checksum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crcs_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crcs_pkg::out_beat_t out_beat_o
);

  logic           accept;
  logic           free;
  crcs_pkg::res_t res;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  crcs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (in_beat_i),
    .res_o    (res)
  );

  crcs_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// File: test/tb_crc32_direct_seeded_checksum.sv
`timescale 1ns / 100ps

class checksum_tracker;
  logic [31:0] crc_reg;
  logic [2:0]  seed_cnt;
  crcs_pkg::out_beat_t sums_due[$];
  int unsigned n_bytes;
  int unsigned n_sums;
  int unsigned n_short;
  int unsigned n_errors;

  function new();
    crc_reg  = '0;
    seed_cnt = '0;
    n_bytes  = 0;
    n_sums   = 0;
    n_short  = 0;
    n_errors = 0;
  endfunction

  function logic [31:0] poly_fold(logic [7:0] top);
    logic [31:0] acc;
    acc = {top, 24'h0};
    repeat (8) begin
      if (acc[31]) begin
        acc = (acc << 1) ^ crcs_pkg::CrcPoly;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

  function void note_byte(crcs_pkg::in_beat_t b);
    crcs_pkg::out_beat_t sum;
    n_bytes++;
    if (seed_cnt < crcs_pkg::SeedBytes) begin
      crc_reg  = {crc_reg[23:0], b.data_byte};
      seed_cnt = seed_cnt + 3'd1;
      if (seed_cnt == crcs_pkg::SeedBytes) begin
        crc_reg = ~crc_reg;
      end
    end else begin
      crc_reg = poly_fold(crc_reg[31:24]) ^ {crc_reg[23:0], b.data_byte};
    end
    if (b.last_byte) begin
      if (seed_cnt < crcs_pkg::SeedBytes) begin
        sum.checksum  = '0;
        sum.too_short = 1'b1;
        n_short++;
      end else begin
        sum.checksum  = ~crc_reg;
        sum.too_short = 1'b0;
      end
      sums_due.push_back(sum);
      crc_reg  = '0;
      seed_cnt = '0;
    end
  endfunction

  function void check_sum(crcs_pkg::out_beat_t got);
    crcs_pkg::out_beat_t want;
    if (sums_due.size() == 0) begin
      $display("%0t: unexpected result beat, expected none actual %08h short %0b",
               $time, got.checksum, got.too_short);
      n_errors++;
      return;
    end
    want = sums_due.pop_front();
    n_sums++;
    if (got.checksum !== want.checksum) begin
      $display("%0t: checksum mismatch expected %08h actual %08h",
               $time, want.checksum, got.checksum);
      n_errors++;
    end
    if (got.too_short !== want.too_short) begin
      $display("%0t: too_short mismatch expected %0b actual %0b",
               $time, want.too_short, got.too_short);
      n_errors++;
    end
  endfunction
endclass

module tb_crc32_direct_seeded_checksum;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned RandBytes  = 1050;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  crcs_pkg::in_beat_t  in_beat_i;
  logic                out_valid_o;
  logic                out_ready_i;
  crcs_pkg::out_beat_t out_beat_o;

  checksum_tracker     sb = new();
  crcs_pkg::in_beat_t  stim_q[$];
  logic                long_hold_req;
  int unsigned         holds_done;
  int unsigned         n_msgs;
  int unsigned         cycles;

  crc32_direct_seeded_checksum u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.sums_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // beat monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_byte(in_beat_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_sum(out_beat_o);
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic last);
    crcs_pkg::in_beat_t b;
    b.data_byte = data;
    b.last_byte = last;
    stim_q.push_back(b);
    if (last) begin
      n_msgs++;
    end
  endtask

  task automatic push_msg(input int unsigned len);
    int unsigned fill;
    logic [7:0]  data;
    fill = $urandom_range(0, 9);
    for (int unsigned k = 0; k < len; k++) begin
      case (fill)
        0:       data = 8'hFF;
        1:       data = 8'h00;
        default: data = 8'($urandom);
      endcase
      push_byte(data, k == len - 1);
    end
  endtask

  task automatic send_byte(input crcs_pkg::in_beat_t b);
    in_valid_i = 1'b1;
    in_beat_i  = b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_all();
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    for (int unsigned i = 0; i < stim_q.size(); i++) begin
      if (i == 300 || i == 750) begin
        long_hold_req = 1'b1;
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 24);
      end
      send_byte(stim_q[i]);
      burst_left--;
    end
    in_valid_i = 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    logic [7:0]  rx_mask;
    rx_mode = 0;
    rx_left = 0;
    rx_mask = '1;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_ready_i = 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
        holds_done++;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mask = 8'($urandom);
          rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        case (rx_mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = 1'($urandom_range(0, 1));
          2: out_ready_i = ($urandom_range(0, 3) == 0);
          default: begin
            out_ready_i = rx_mask[0];
            rx_mask = {rx_mask[0], rx_mask[7:1]};
          end
        endcase
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned len;
    cycles        = 0;
    holds_done    = 0;
    n_msgs        = 0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_beat_i     = '0;

    // short messages of one to three bytes
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b1);
    // exactly four bytes
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b1);
    // table steps after the seed
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
    // restart right after a long message
    push_byte(8'hFF, 1'b1);

    while (stim_q.size() < 22 + RandBytes) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        len = $urandom_range(1, 3);
      end else if (sel < 7) begin
        len = $urandom_range(4, 12);
      end else if (sel < 9) begin
        len = $urandom_range(13, 40);
      end else begin
        len = 4;
      end
      push_msg(len);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_all();

    while (sb.sums_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes in %0d messages, %0d short; checked %0d results",
             sb.n_bytes, n_msgs, sb.n_short, sb.n_sums);
    $display("receiver held off %0d times for %0d cycles each", holds_done, LongHold);
    if (sb.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
